>>> hw/rtl/cuv_pkg.sv
// ----------------------------------------------------------------------------
// cuv_pkg: shared types and constants of the comment UTF-8 validator
// Status codes, phase codes, byte constants and the sequence length decode.
// ----------------------------------------------------------------------------
`default_nettype none

package cuv_pkg;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_EQUALS  = 3'd1;
    localparam logic [2:0] ST_BAD_NAME   = 3'd2;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
    localparam logic [2:0] ST_TRUNCATED  = 3'd4;
    localparam logic [2:0] ST_BAD_SEQ    = 3'd5;

    // phase codes
    localparam logic [1:0] PH_NAME  = 2'd0;
    localparam logic [1:0] PH_VALUE = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;

    // byte constants
    localparam logic [7:0] B_EQUALS    = 8'h3D;
    localparam logic [7:0] B_NAME_LO   = 8'h20;
    localparam logic [7:0] B_NAME_HI   = 8'h7D;
    localparam logic [7:0] B_LEAD_BAD  = 8'hFE;
    localparam logic [7:0] B_LEAD_E0   = 8'hE0;
    localparam logic [7:0] B_LEAD_ED   = 8'hED;
    localparam logic [7:0] B_LEAD_F0   = 8'hF0;
    localparam logic [7:0] B_LEAD_F4   = 8'hF4;
    localparam logic [7:0] B_CONT_LO   = 8'h80;
    localparam logic [7:0] B_CONT_HI   = 8'hBF;
    localparam logic [7:0] B_E0_LO     = 8'hA0;
    localparam logic [7:0] B_ED_HI     = 8'h9F;
    localparam logic [7:0] B_F0_LO     = 8'h90;
    localparam logic [7:0] B_F4_HI     = 8'h8F;
    localparam logic [6:0] B_OVERLONG2 = 7'h60; // 0xC0 and 0xC1 share these bits

    typedef struct packed {
        logic [1:0] phase;
        logic       name_bad;
        logic [2:0] seq_left;
        logic [7:0] seq_lead;
        logic       seq_bad;
        logic [2:0] first_err;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:     PH_NAME,
        name_bad:  1'b0,
        seq_left:  3'd0,
        seq_lead:  8'd0,
        seq_bad:   1'b0,
        first_err: ST_OK
    };

    // total sequence length from its lead byte
    function automatic logic [2:0] seq_total(input logic [7:0] lead);
        logic [2:0] total;
        if (lead < 8'hE0) begin
            total = 3'd2;
        end else if (lead < 8'hF0) begin
            total = 3'd3;
        end else if (lead < 8'hF8) begin
            total = 3'd4;
        end else if (lead < 8'hFC) begin
            total = 3'd5;
        end else begin
            total = 3'd6;
        end
        return total;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cuv_step.sv
// ----------------------------------------------------------------------------
// cuv_step: per-byte state update
// Combinational next state and end-of-comment status for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cuv_step (
    input  wire cuv_pkg::t_state i_state,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_last_byte,
    output cuv_pkg::t_state      o_state,
    output logic [2:0]           o_status
);
    import cuv_pkg::*;

    t_state     upd;
    logic [2:0] total_new;
    logic [2:0] total_open;
    logic [2:0] left_dec;
    logic       is_cont;
    logic       cont_ok;

    always_comb begin
        upd        = i_state;
        total_new  = seq_total(i_data_byte);
        total_open = seq_total(i_state.seq_lead);
        left_dec   = i_state.seq_left - 3'd1;
        is_cont    = (i_data_byte[7:6] == 2'b10);
        cont_ok    = is_cont;

        // first continuation byte of the special leads has a narrower range
        if (i_state.seq_left == total_open - 3'd1) begin
            if (i_state.seq_lead == B_LEAD_E0) begin
                cont_ok = i_data_byte inside {[B_E0_LO:B_CONT_HI]};
            end else if (i_state.seq_lead == B_LEAD_ED) begin
                cont_ok = i_data_byte inside {[B_CONT_LO:B_ED_HI]};
            end else if (i_state.seq_lead == B_LEAD_F0) begin
                cont_ok = i_data_byte inside {[B_F0_LO:B_CONT_HI]};
            end else if (i_state.seq_lead == B_LEAD_F4) begin
                cont_ok = i_data_byte inside {[B_CONT_LO:B_F4_HI]};
            end
        end

        case (i_state.phase)
            PH_NAME: begin
                if (i_data_byte == 8'd0) begin
                    upd.phase     = PH_DONE;
                    upd.first_err = ST_NO_EQUALS;
                end else if (i_data_byte == B_EQUALS) begin
                    if (i_state.name_bad) begin
                        upd.phase     = PH_DONE;
                        upd.first_err = ST_BAD_NAME;
                    end else begin
                        upd.phase = PH_VALUE;
                    end
                end else if (!(i_data_byte inside {[B_NAME_LO:B_NAME_HI]})) begin
                    upd.name_bad = 1'b1;
                end
            end
            PH_VALUE: begin
                if (i_state.seq_left == 3'd0) begin
                    if (!i_data_byte[7]) begin
                        // plain ASCII
                    end else if (is_cont || i_data_byte >= B_LEAD_BAD) begin
                        upd.phase     = PH_DONE;
                        upd.first_err = ST_BAD_LENGTH;
                    end else begin
                        upd.seq_lead = i_data_byte;
                        upd.seq_left = total_new - 3'd1;
                        upd.seq_bad  = (total_new == 3'd2 &&
                                        i_data_byte[7:1] == B_OVERLONG2) ||
                                       (total_new == 3'd4 && i_data_byte > B_LEAD_F4) ||
                                       (total_new >= 3'd5);
                    end
                end else begin
                    upd.seq_bad  = i_state.seq_bad | ~cont_ok;
                    upd.seq_left = left_dec;
                    if (left_dec == 3'd0 && upd.seq_bad) begin
                        upd.phase     = PH_DONE;
                        upd.first_err = ST_BAD_SEQ;
                    end
                end
            end
            default: begin
                // error latched: bytes ignored
            end
        endcase

        case (upd.phase)
            PH_NAME:  o_status = ST_NO_EQUALS;
            PH_VALUE: o_status = (upd.seq_left != 3'd0) ? ST_TRUNCATED : ST_OK;
            default:  o_status = upd.first_err;
        endcase

        o_state = i_last_byte ? STATE_RESET : upd;
    end

endmodule

`default_nettype wire

>>> hw/rtl/comment_utf8_validator_core.sv
// Comment UTF-8 validator. Takes the bytes of one NAME=value comment, one
// byte per cycle, with i_last_byte on the final byte, and gives one status
// item for each comment on the final byte: 0 ok, 1 no '=', 2 bad name byte,
// 3 bad length marker, 4 truncated sequence, 5 invalid sequence. The first
// error found wins. Each byte goes through an input register, a single
// combinational state update and, for the final byte, the status register,
// so a byte can be taken every cycle and the status is registered when the
// final byte leaves the input register. Only a final byte waits on a status that
// has not yet been taken; other bytes keep flowing while the output is stalled.
// State returns to reset after every comment.
// ----------------------------------------------------------------------------
// comment_utf8_validator_core: top level
// Input register, validator state, status output register.
// ----------------------------------------------------------------------------
`default_nettype none

module comment_utf8_validator_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [2:0]      o_status
);
    import cuv_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       n_in_valid;

    // validator state
    t_state     r_state;
    t_state     n_state;

    // status register
    logic       r_out_valid;
    logic [2:0] r_out_status;
    logic       n_out_valid;

    t_state     step_state;
    logic [2:0] step_status;
    logic       out_free;
    logic       fire;
    logic       in_accept;

    cuv_step u_step (
        .i_state     (r_state),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_state     (step_state),
        .o_status    (step_status)
    );

    // status slot is free if empty or being taken this cycle
    assign out_free  = !r_out_valid || !i_out_stall;
    // a held byte moves on unless it is a final byte with nowhere to go
    assign fire      = r_in_valid && (!r_in_last || out_free);
    assign o_in_stall = r_in_valid && !fire;
    assign in_accept = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end

        n_state = r_state;
        if (fire) begin
            n_state = step_state;
        end

        n_out_valid = r_out_valid;
        if (fire && r_in_last) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_state     <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
        if (fire && r_in_last) begin
            r_out_status <= step_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_BAD_SEQ))
        else $error("status code out of range");

    a_seq_in_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.seq_left != 3'd0) |-> (r_state.phase == PH_VALUE))
        else $error("open sequence outside value phase");

    a_last_gives_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_last) |=> (o_out_valid && r_state == STATE_RESET))
        else $error("final byte did not give a status and clear state");

    a_stall_only_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_in_last && r_out_valid))
        else $error("input stalled without a held final byte");

endmodule

`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of comment_utf8_validator_core
// Sends NAME=value comments byte by byte, predicts the status of each comment
// with its own model of the name and UTF-8 rules, and checks every status
// item the block gives. Directed comments first, then random comments back to
// back, then under bursty input and a stalling output.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import cuv_pkg::*;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_last_byte = 1'b0;
    logic       i_out_stall = 1'b0;
    wire logic       o_in_stall;
    wire logic       o_out_valid;
    wire logic [2:0] o_status;

    comment_utf8_validator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Status predictor: own copy of the validator state
    // ------------------------------------------------------------------------
    typedef struct {
        logic [1:0] phase;
        logic       name_bad;   // a name byte fell outside 0x20..0x7D
        logic       stopped;    // zero byte ended the '=' search
        logic [2:0] left;       // continuation bytes still owed
        logic [7:0] lead;       // lead byte of the open sequence
        logic       seq_bad;    // open sequence already holds a bad byte
        logic [2:0] err;        // first error latched
    } t_comment_state;

    t_comment_state pred;
    logic [2:0]     expected_status[$];
    int unsigned    mismatch_count = 0;
    int unsigned    bytes_sent     = 0;

    function automatic void pred_clear();
        pred.phase    = PH_NAME;
        pred.name_bad = 1'b0;
        pred.stopped  = 1'b0;
        pred.left     = 3'd0;
        pred.lead     = 8'h00;
        pred.seq_bad  = 1'b0;
        pred.err      = ST_OK;
    endfunction

    function automatic void pred_latch(input logic [2:0] code);
        pred.err   = code;
        pred.phase = PH_DONE;
    endfunction

    // length of a UTF-8 sequence (5 and 6 byte forms included) from its lead
    function automatic logic [2:0] utf8_seq_len(input logic [7:0] lead);
        casez (lead)
            8'b1111_11??: return 3'd6;
            8'b1111_10??: return 3'd5;
            8'b1111_0???: return 3'd4;
            8'b1110_????: return 3'd3;
            default:      return 3'd2;
        endcase
    endfunction

    // advance the prediction by one byte; returns 1 with the status on a last byte
    function automatic bit predict_byte(input logic [7:0] b, input logic last,
                                        output logic [2:0] status);
        logic [2:0] total;
        logic [2:0] pos;
        logic       ok;
        status = ST_OK;
        if (pred.phase == PH_NAME) begin
            if (b == 8'h00) begin
                pred.stopped = 1'b1;
                pred_latch(ST_NO_EQUALS);
            end else if (b == B_EQUALS) begin
                if (pred.name_bad) begin
                    pred_latch(ST_BAD_NAME);
                end else begin
                    pred.phase = PH_VALUE;
                end
            end else if (b < B_NAME_LO || b > B_NAME_HI) begin
                pred.name_bad = 1'b1;
            end
        end else if (pred.phase == PH_VALUE) begin
            if (pred.left == 3'd0) begin
                if (b[7]) begin
                    if (b[7:6] == 2'b10 || b >= B_LEAD_BAD) begin
                        pred_latch(ST_BAD_LENGTH);
                    end else begin
                        total        = utf8_seq_len(b);
                        pred.lead    = b;
                        pred.left    = total - 3'd1;
                        pred.seq_bad = (total == 3'd2 && b[7:1] == B_OVERLONG2) ||
                                       (total == 3'd4 && b > B_LEAD_F4) ||
                                       total >= 3'd5;
                    end
                end
            end else begin
                pos = utf8_seq_len(pred.lead) - pred.left;
                ok  = (b[7:6] == 2'b10);
                // tighter second-byte ranges: overlong, surrogate, above U+10FFFF
                if (pos == 3'd1) begin
                    case (pred.lead)
                        B_LEAD_E0: ok = b >= B_E0_LO && b <= B_CONT_HI;
                        B_LEAD_ED: ok = b >= B_CONT_LO && b <= B_ED_HI;
                        B_LEAD_F0: ok = b >= B_F0_LO && b <= B_CONT_HI;
                        B_LEAD_F4: ok = b >= B_CONT_LO && b <= B_F4_HI;
                        default: ;
                    endcase
                end
                if (!ok) pred.seq_bad = 1'b1;
                pred.left = pred.left - 3'd1;
                if (pred.left == 3'd0 && pred.seq_bad) pred_latch(ST_BAD_SEQ);
            end
        end
        if (!last) return 1'b0;
        case (pred.phase)
            PH_NAME:  status = ST_NO_EQUALS;
            PH_VALUE: status = (pred.left != 3'd0) ? ST_TRUNCATED : ST_OK;
            default:  status = pred.err;
        endcase
        pred_clear();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    logic [7:0]  comment_buf[$];
    bit          gaps_on    = 1'b0;
    int unsigned burst_left = 0;

    task automatic send_byte(input logic [7:0] b, input logic last);
        logic [2:0] st;
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (predict_byte(b, last, st)) expected_status.push_back(st);
        bytes_sent++;
    endtask

    // send the buffered comment, final byte flagged; gaps may fall mid-comment
    task automatic send_comment();
        for (int k = 0; k < comment_buf.size(); k++) begin
            if (gaps_on) begin
                if (burst_left == 0) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
            end
            send_byte(comment_buf[k], k == comment_buf.size() - 1);
        end
        comment_buf.delete();
    endtask

    // hold the input off until every pending status has come back
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_status.size() != 0);
    endtask

    // mostly well-formed comments with random content, plus noise and damage
    task automatic build_random_comment();
        int unsigned kind;
        int unsigned n;
        int unsigned cls;
        logic [20:0] cp;
        logic [7:0]  lead;
        logic [7:0]  v;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            n = $urandom_range(1, 8);
            repeat (n) comment_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(0, 5);
            repeat (n) begin
                if ($urandom_range(0, 19) == 0) begin
                    v = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h1F))
                                             : 8'($urandom_range(8'h7E, 8'hFF));
                end else begin
                    v = 8'($urandom_range(8'h20, 8'h7C));
                    if (v >= B_EQUALS) v = v + 8'd1;
                end
                comment_buf.push_back(v);
            end
            if ($urandom_range(0, 15) != 0) comment_buf.push_back(B_EQUALS);
            n = $urandom_range(0, 5);
            repeat (n) begin
                cls = $urandom_range(0, 9);
                if (cls == 8) begin
                    // overlong lead or lead with a tight second-byte range, any continuation
                    case ($urandom_range(0, 5))
                        0:       lead = 8'hC0;
                        1:       lead = 8'hC1;
                        2:       lead = B_LEAD_E0;
                        3:       lead = B_LEAD_ED;
                        4:       lead = B_LEAD_F0;
                        default: lead = B_LEAD_F4;
                    endcase
                end else if (cls == 9) begin
                    lead = 8'($urandom_range(8'hF5, 8'hFD));
                end
                if (cls >= 8) begin
                    comment_buf.push_back(lead);
                    repeat (utf8_seq_len(lead) - 1)
                        comment_buf.push_back(8'($urandom_range(B_CONT_LO, B_CONT_HI)));
                end else begin
                    case (cls)
                        0, 1, 2: cp = 21'($urandom_range(0, 16'h7F));
                        3:       cp = 21'($urandom_range(16'h80, 16'h7FF));
                        4:       cp = 21'($urandom_range(16'h800, 16'hFFFF));
                        5:       cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
                        6: begin
                            case ($urandom_range(0, 8))
                                0:       cp = 21'h7F;
                                1:       cp = 21'h80;
                                2:       cp = 21'h7FF;
                                3:       cp = 21'h800;
                                4:       cp = 21'hD7FF;
                                5:       cp = 21'hE000;
                                6:       cp = 21'hFFFF;
                                7:       cp = 21'h10000;
                                default: cp = 21'h10FFFF;
                            endcase
                        end
                        default: cp = 21'($urandom_range(32'h110000, 32'h1FFFFF));
                    endcase
                    if (cp < 21'h80) begin
                        comment_buf.push_back(cp[7:0]);
                    end else if (cp < 21'h800) begin
                        comment_buf.push_back({3'b110, cp[10:6]});
                        comment_buf.push_back({2'b10, cp[5:0]});
                    end else if (cp < 21'h10000) begin
                        comment_buf.push_back({4'b1110, cp[15:12]});
                        comment_buf.push_back({2'b10, cp[11:6]});
                        comment_buf.push_back({2'b10, cp[5:0]});
                    end else begin
                        comment_buf.push_back({5'b11110, cp[20:18]});
                        comment_buf.push_back({2'b10, cp[17:12]});
                        comment_buf.push_back({2'b10, cp[11:6]});
                        comment_buf.push_back({2'b10, cp[5:0]});
                    end
                end
            end
            if (comment_buf.size() == 0) comment_buf.push_back(B_EQUALS);
            if (kind < 25) begin
                comment_buf[$urandom_range(0, comment_buf.size() - 1)] =
                    8'($urandom_range(0, 255));
            end else if (kind < 35) begin
                // cut the comment short, usually inside a sequence
                repeat ($urandom_range(1, 3))
                    if (comment_buf.size() > 1) void'(comment_buf.pop_back());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall runs of random length, per mode
    // ------------------------------------------------------------------------
    typedef enum logic [1:0] {RX_READY, RX_CHOPPY, RX_SLUGGISH} t_rx_mode;

    t_rx_mode    rx_mode = RX_READY;
    int unsigned rx_run  = 0;

    always @(posedge i_clk) begin
        if (rx_mode == RX_READY) begin
            i_out_stall <= 1'b0;
        end else if (rx_run == 0) begin
            if (i_out_stall) begin
                i_out_stall <= 1'b0;
                rx_run = $urandom_range(1, (rx_mode == RX_CHOPPY) ? 4 : 3);
            end else begin
                i_out_stall <= 1'b1;
                rx_run = $urandom_range(1, (rx_mode == RX_CHOPPY) ? 3 : 30);
            end
        end else begin
            rx_run--;
        end
    end

    // ------------------------------------------------------------------------
    // Status checker
    // ------------------------------------------------------------------------
    logic [2:0] status_want;

    task automatic report_mismatch(input string what, input logic [2:0] want,
                                   input logic [2:0] got);
        $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_status.size() == 0) begin
                report_mismatch("status with no comment pending", 3'bxxx, o_status);
            end else begin
                status_want = expected_status.pop_front();
                if (o_status !== status_want)
                    report_mismatch("status", status_want, o_status);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        gaps_on = 1'b0;
        rx_mode = RX_READY;
        comment_buf = '{B_NAME_LO, B_EQUALS};               // empty value
        send_comment();
        comment_buf = '{8'h01, 8'h00};                      // zero after bad name byte
        send_comment();
        comment_buf = '{8'hFF};                             // no '=' at all
        send_comment();
        comment_buf = '{8'h7E, B_EQUALS, 8'hC0};            // bad name, value ignored
        send_comment();
        comment_buf = '{B_EQUALS, 8'h80, 8'h78};            // stray continuation
        send_comment();
        comment_buf = '{B_EQUALS, B_LEAD_BAD};              // 0xFE lead
        send_comment();
        comment_buf = '{B_EQUALS, 8'hF8, B_CONT_LO};        // cut-short 5-byte lead
        send_comment();
        comment_buf = '{B_EQUALS, 8'hC1, B_CONT_HI};        // overlong pair
        send_comment();
        comment_buf = '{B_NAME_HI, B_EQUALS, B_LEAD_F4, B_F4_HI, B_CONT_HI, B_CONT_HI};
        send_comment();                                     // U+10FFFF
        wait_all_results();
    endtask

    task automatic test_random(input bit gaps, input t_rx_mode mode,
                               input int unsigned n_bytes);
        int unsigned stop_at;
        int unsigned count;
        gaps_on = gaps;
        rx_mode = mode;
        stop_at = bytes_sent + n_bytes;
        count   = 0;
        while (bytes_sent < stop_at) begin
            build_random_comment();
            send_comment();
            count++;
            if (count % 40 == 0) wait_all_results();
        end
        wait_all_results();
    endtask

    initial begin
        pred_clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1'b0, RX_READY, 250);      // back to back, no stalls
        test_random(1'b1, RX_CHOPPY, 500);     // bursts and short stalls
        test_random(1'b1, RX_SLUGGISH, 300);   // long output stalls
        wait_all_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_status.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
